// ----- hw/rtl/twcw_pkg.sv -----
package twcw_pkg;

    // Cell store geometry (window cell (r, c) lives at {r, c})
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 128;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int ADDR_W   = ROW_AW + COL_AW;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;

    // Field and register widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int CROW_W  = 6;
    localparam int CCOL_W  = 7;
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 8;
    localparam int COLOR_W = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NL = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SP = 8'd32;

    // Register reset values
    localparam logic [ROWS_W-1:0]  RST_ROWS = 7'd25;
    localparam logic [COLS_W-1:0]  RST_COLS = 8'd80;
    localparam logic [COLOR_W-1:0] RST_FG   = 32'h00FF_FFFF;
    localparam logic [COLOR_W-1:0] RST_BG   = 32'h0000_0000;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT   = 2'd0,
        FN_MOVE  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_ROWS   = 3'd0,
        REG_COLS   = 3'd1,
        REG_BOXED  = 3'd2,
        REG_SCROLL = 3'd3,
        REG_FG     = 3'd4,
        REG_BG     = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        K_CHAR      = 3'd0,
        K_NEWLINE   = 3'd1,
        K_RETURN    = 3'd2,
        K_BACKSPACE = 3'd3,
        K_MOVE      = 3'd4,
        K_CLEAR     = 3'd5,
        K_READ      = 3'd6
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
        logic [CROW_W-1:0] row;
        logic [CCOL_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

    typedef struct packed {
        logic init_busy;
        logic pop;
    } back_stat_t;

    typedef struct packed {
        logic [ROWS_W-1:0]  rows;
        logic [COLS_W-1:0]  cols;
        logic               boxed;
        logic               scroll_en;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } cfg_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } cell_t;

    localparam cell_t RESET_CELL = '{ch: CH_SP, fg: RST_FG, bg: RST_BG};

endpackage

// ----- hw/rtl/twcw_cell_store.sv -----
module twcw_cell_store
    import twcw_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  cell_t             wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output cell_t             rd_data
);

    cell_t mem [CELLS];
    cell_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/twcw_front.sv -----
module twcw_front
    import twcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [CROW_W-1:0] target_row,
    input  logic [CCOL_W-1:0] target_col,
    input  back_stat_t        bstat,
    output qhead_t            qhead
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    cmd_t              cmd_in;

    assign in_stall = (cnt_reg == QCNT_W'(QDEPTH)) || bstat.init_busy;
    assign push     = in_valid && !in_stall;

    // Classify the transfer into one back-end command
    always_comb
    begin
        cmd_in.ch  = char_code;
        cmd_in.row = target_row;
        cmd_in.col = target_col;
        case (func)
            FN_PUT:
            begin
                case (char_code)
                    CH_NL:   cmd_in.kind = K_NEWLINE;
                    CH_CR:   cmd_in.kind = K_RETURN;
                    CH_BS:   cmd_in.kind = K_BACKSPACE;
                    default: cmd_in.kind = K_CHAR;
                endcase
            end
            FN_MOVE:  cmd_in.kind = K_MOVE;
            FN_CLEAR: cmd_in.kind = K_CLEAR;
            default:  cmd_in.kind = K_READ;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (bstat.pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !bstat.pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && bstat.pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign qhead.valid = (cnt_reg != '0);
    assign qhead.cmd   = q_reg[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !bstat.pop) |=> (cnt_reg == QCNT_W'($past(cnt_reg) + 1'b1)))
        else $error("queue fill count did not advance on push");
`endif

endmodule

// ----- hw/rtl/twcw_back.sv -----
module twcw_back
    import twcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  qhead_t             qhead,
    output back_stat_t         bstat,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CROW_W-1:0]  cursor_row,
    output logic [CCOL_W-1:0]  cursor_col,
    output logic [CHAR_W-1:0]  cell_char,
    output logic [COLOR_W-1:0] cell_fg,
    output logic [COLOR_W-1:0] cell_bg,
    output logic               cell_valid
);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_CLEAR  = 5'b01000,
        S_SCROLL = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;

    logic [CROW_W-1:0] cur_row_reg, cur_row_next;
    logic [CCOL_W-1:0] cur_col_reg, cur_col_next;
    logic [ADDR_W-1:0] init_addr_reg, init_addr_next;

    // Sweep counters, shared by clear and scroll
    logic [CROW_W-1:0] sw_r_reg, sw_r_next;
    logic [CCOL_W-1:0] sw_c_reg, sw_c_next;
    logic [ROWS_W-1:0] lim_r_reg, lim_r_next;
    logic [COLS_W-1:0] lim_c_reg, lim_c_next;
    logic              sw_off_reg, sw_off_next;
    logic              sw_act_reg, sw_act_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              wr_blank_reg, wr_blank_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [CROW_W-1:0]  out_row_reg, out_row_next;
    logic [CCOL_W-1:0]  out_col_reg, out_col_next;
    cell_t              out_cell_reg, out_cell_next;
    logic               out_cv_reg, out_cv_next;

    // Store port
    logic              st_wr_en;
    logic [ADDR_W-1:0] st_wr_addr;
    cell_t             st_wr_data;
    logic              st_rd_en;
    logic [ADDR_W-1:0] st_rd_addr;
    cell_t             st_rd_data;

    // Window geometry
    logic [ROWS_W-1:0] h;
    logic [COLS_W-1:0] w;
    logic [ROWS_W-1:0] ih;
    logic [COLS_W-1:0] iw;
    logic              off;
    logic              int_empty;
    cell_t             blank;

    // Put-character datapath
    logic [ROWS_W-1:0] cy0, nr, wrow, wrow_abs;
    logic [COLS_W-1:0] cx0, nc, wcol, wcol_abs;
    logic              down, pc_wr, pc_scroll, pc_in_win;
    logic [CHAR_W-1:0] pc_ch;
    logic [ADDR_W-1:0] pc_addr;

    // Move and read datapath
    logic [ROWS_W-1:0] mv_row;
    logic [COLS_W-1:0] mv_col;
    logic              rd_in_win;

    // Sweep addressing
    logic [ROWS_W-1:0] sw_row_abs, src_row_abs;
    logic [COLS_W-1:0] sw_col_abs;
    logic [ADDR_W-1:0] sw_addr, src_addr;
    logic              sw_last_col, sw_last_row;

    logic slot_free, pop;
    cmd_t cmd;

    twcw_cell_store u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    assign cmd       = qhead.cmd;
    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == S_IDLE) && qhead.valid && slot_free;

    assign bstat.pop       = pop;
    assign bstat.init_busy = (state_reg == S_INIT);

    always_comb
    begin
        h   = (cfg.rows > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : cfg.rows;
        w   = (cfg.cols > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : cfg.cols;
        off = cfg.boxed;
        if (cfg.boxed)
        begin
            ih = (h > ROWS_W'(2)) ? h - ROWS_W'(2) : '0;
            iw = (w > COLS_W'(2)) ? w - COLS_W'(2) : '0;
        end
        else
        begin
            ih = h;
            iw = w;
        end
        int_empty = (ih == '0) || (iw == '0);
        blank     = '{ch: CH_SP, fg: cfg.fg, bg: cfg.bg};
    end

    // Cursor stepping for printable, newline and backspace
    always_comb
    begin
        cy0       = {1'b0, cur_row_reg};
        cx0       = {1'b0, cur_col_reg};
        nr        = cy0;
        nc        = cx0;
        wrow      = cy0;
        wcol      = cx0;
        down      = 1'b0;
        pc_wr     = 1'b0;
        pc_scroll = 1'b0;
        pc_ch     = cmd.ch;
        case (cmd.kind)
            K_BACKSPACE:
            begin
                if (cx0 != '0)
                begin
                    nc = cx0 - 1'b1;
                end
                else if (cy0 != '0)
                begin
                    nr = cy0 - 1'b1;
                    nc = iw - 1'b1;
                end
                pc_wr = 1'b1;
                pc_ch = CH_SP;
                wrow  = nr;
                wcol  = nc;
            end
            K_NEWLINE:
            begin
                down = 1'b1;
            end
            K_CHAR:
            begin
                pc_wr = 1'b1;
                nc    = cx0 + 1'b1;
                if (nc >= iw)
                begin
                    down = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (down)
        begin
            nc = '0;
            nr = cy0 + 1'b1;
            if (nr >= ih)
            begin
                pc_scroll = cfg.scroll_en;
                nr        = ih - 1'b1;
            end
        end
        wrow_abs  = wrow + ROWS_W'(off);
        wcol_abs  = wcol + COLS_W'(off);
        pc_in_win = (wrow_abs < h) && (wcol_abs < w);
        pc_addr   = {wrow_abs[ROW_AW-1:0], wcol_abs[COL_AW-1:0]};
    end

    always_comb
    begin
        if ({1'b0, cmd.row} >= ih)
        begin
            mv_row = (ih != '0) ? ih - 1'b1 : '0;
        end
        else
        begin
            mv_row = {1'b0, cmd.row};
        end
        if ({1'b0, cmd.col} >= iw)
        begin
            mv_col = (iw != '0) ? iw - 1'b1 : '0;
        end
        else
        begin
            mv_col = {1'b0, cmd.col};
        end
        rd_in_win = ({1'b0, cmd.row} < h) && ({1'b0, cmd.col} < w);
    end

    always_comb
    begin
        sw_row_abs  = {1'b0, sw_r_reg} + ROWS_W'(sw_off_reg);
        src_row_abs = sw_row_abs + 1'b1;
        sw_col_abs  = {1'b0, sw_c_reg} + COLS_W'(sw_off_reg);
        sw_addr     = {sw_row_abs[ROW_AW-1:0], sw_col_abs[COL_AW-1:0]};
        src_addr    = {src_row_abs[ROW_AW-1:0], sw_col_abs[COL_AW-1:0]};
        sw_last_col = ({1'b0, sw_c_reg} + 1'b1) == lim_c_reg;
        sw_last_row = ({1'b0, sw_r_reg} + 1'b1) == lim_r_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        init_addr_next = init_addr_reg;
        sw_r_next      = sw_r_reg;
        sw_c_next      = sw_c_reg;
        lim_r_next     = lim_r_reg;
        lim_c_next     = lim_c_reg;
        sw_off_next    = sw_off_reg;
        sw_act_next    = sw_act_reg;
        wr_pend_next   = 1'b0;
        wr_blank_next  = wr_blank_reg;
        wr_addr_next   = wr_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_cell_next  = out_cell_reg;
        out_cv_next    = out_cv_reg;
        st_wr_en       = 1'b0;
        st_wr_addr     = sw_addr;
        st_wr_data     = blank;
        st_rd_en       = 1'b0;
        st_rd_addr     = src_addr;

        case (state_reg)
            S_INIT:
            begin
                st_wr_en       = 1'b1;
                st_wr_addr     = init_addr_reg;
                st_wr_data     = RESET_CELL;
                init_addr_next = init_addr_reg + 1'b1;
                if (init_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (pop)
                begin
                    // Most commands finish here; default to a cursor-only result
                    out_valid_next = 1'b1;
                    out_cell_next  = '0;
                    out_cv_next    = 1'b0;
                    case (cmd.kind)
                        K_MOVE:
                        begin
                            cur_row_next = mv_row[CROW_W-1:0];
                            cur_col_next = mv_col[CCOL_W-1:0];
                        end
                        K_RETURN:
                        begin
                            if (!int_empty)
                            begin
                                cur_col_next = '0;
                            end
                        end
                        K_CHAR, K_NEWLINE, K_BACKSPACE:
                        begin
                            if (!int_empty)
                            begin
                                st_wr_en     = pc_wr && pc_in_win;
                                st_wr_addr   = pc_addr;
                                st_wr_data   = '{ch: pc_ch, fg: cfg.fg, bg: cfg.bg};
                                cur_row_next = nr[CROW_W-1:0];
                                cur_col_next = nc[CCOL_W-1:0];
                                if (pc_scroll)
                                begin
                                    // Hold the result until the interior has moved up
                                    out_valid_next = 1'b0;
                                    state_next     = S_SCROLL;
                                    sw_r_next      = '0;
                                    sw_c_next      = '0;
                                    lim_r_next     = ih;
                                    lim_c_next     = iw;
                                    sw_off_next    = off;
                                    sw_act_next    = 1'b1;
                                end
                            end
                        end
                        K_CLEAR:
                        begin
                            cur_row_next = '0;
                            cur_col_next = '0;
                            if ((h != '0) && (w != '0))
                            begin
                                out_valid_next = 1'b0;
                                state_next     = S_CLEAR;
                                sw_r_next      = '0;
                                sw_c_next      = '0;
                                lim_r_next     = h;
                                lim_c_next     = w;
                                sw_off_next    = 1'b0;
                                sw_act_next    = 1'b1;
                            end
                        end
                        K_READ:
                        begin
                            if (rd_in_win)
                            begin
                                out_valid_next = 1'b0;
                                st_rd_en       = 1'b1;
                                st_rd_addr     = {cmd.row[ROW_AW-1:0], cmd.col[COL_AW-1:0]};
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_READ:
            begin
                out_valid_next = 1'b1;
                out_cell_next  = st_rd_data;
                out_cv_next    = 1'b1;
                state_next     = S_IDLE;
            end

            S_CLEAR:
            begin
                st_wr_en   = 1'b1;
                st_wr_data = blank;
                if (sw_last_col)
                begin
                    sw_c_next = '0;
                    sw_r_next = sw_r_reg + 1'b1;
                end
                else
                begin
                    sw_c_next = sw_c_reg + 1'b1;
                end
                if (sw_last_col && sw_last_row)
                begin
                    sw_act_next    = 1'b0;
                    out_valid_next = 1'b1;
                    out_cell_next  = '0;
                    out_cv_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            S_SCROLL:
            begin
                // Read the cell below, write it one row up on the next cycle
                if (wr_pend_reg)
                begin
                    st_wr_en   = 1'b1;
                    st_wr_addr = wr_addr_reg;
                    st_wr_data = wr_blank_reg ? blank : st_rd_data;
                end
                if (sw_act_reg)
                begin
                    st_rd_en      = !sw_last_row;
                    wr_pend_next  = 1'b1;
                    wr_addr_next  = sw_addr;
                    wr_blank_next = sw_last_row;
                    if (sw_last_col)
                    begin
                        sw_c_next = '0;
                        sw_r_next = sw_r_reg + 1'b1;
                    end
                    else
                    begin
                        sw_c_next = sw_c_reg + 1'b1;
                    end
                    if (sw_last_col && sw_last_row)
                    begin
                        sw_act_next = 1'b0;
                    end
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = '0;
                    out_cv_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_valid_next && !(out_valid_reg && out_stall))
        begin
            out_row_next = cur_row_next;
            out_col_next = cur_col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            init_addr_reg <= '0;
            sw_act_reg    <= 1'b0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            init_addr_reg <= init_addr_next;
            sw_act_reg    <= sw_act_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_r_reg     <= sw_r_next;
        sw_c_reg     <= sw_c_next;
        lim_r_reg    <= lim_r_next;
        lim_c_reg    <= lim_c_next;
        sw_off_reg   <= sw_off_next;
        wr_blank_reg <= wr_blank_next;
        wr_addr_reg  <= wr_addr_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_cell_reg <= out_cell_next;
        out_cv_reg   <= out_cv_next;
    end

    assign out_valid  = out_valid_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign cell_char  = out_cell_reg.ch;
    assign cell_fg    = out_cell_reg.fg;
    assign cell_bg    = out_cell_reg.bg;
    assign cell_valid = out_cv_reg;

`ifndef NO_ASSERTIONS
    a_sweep_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        sw_act_reg |-> (({1'b0, sw_r_reg} < lim_r_reg) && ({1'b0, sw_c_reg} < lim_c_reg)))
        else $error("sweep counter left its bounds");

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != S_INIT))
        else $error("result produced during clearing pass");

    a_move_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (cmd.kind == K_MOVE) && (ih != '0)) |=> ({1'b0, cur_row_reg} < $past(ih)))
        else $error("move left cursor row outside interior");

    a_pend_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == S_SCROLL))
        else $error("pending scroll write outside scroll sweep");
`endif

endmodule

// ----- hw/rtl/text_window_char_writer.sv -----
// Channel   Handshake            Payload
// cfg       psel/penable/pready  paddr, pwdata -> register, prdata on read
// in        in_valid/in_stall    func, char_code, target_row, target_col
// out       out_valid/out_stall  cursor_row, cursor_col, cell_char, cell_fg, cell_bg, cell_valid
//
// After reset the cell store is swept to spaces in the reset colours, all 8192 cells,
// with in_stall held high; register writes are taken during the sweep.
// Move, return, backspace, put character and newline finish in the idle state unless they
// scroll; a read passes through a read state for the store's registered output. The back
// end pops a queued transfer only while idle with a free result register. Clear sweeps
// every window cell (an empty window is not swept) and a scroll every interior cell, paced
// by the single write port of the cell store (one cell per cycle).
// A two-deep command queue keeps taking transfers until full while a result waits on out_stall.
module text_window_char_writer
    import twcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [CROW_W-1:0]  target_row,
    input  logic [CCOL_W-1:0]  target_col,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [CROW_W-1:0]  cursor_row,
    output logic [CCOL_W-1:0]  cursor_col,
    output logic [CHAR_W-1:0]  cell_char,
    output logic [COLOR_W-1:0] cell_fg,
    output logic [COLOR_W-1:0] cell_bg,
    output logic               cell_valid
);

    logic [ROWS_W-1:0]  rows_reg;
    logic [COLS_W-1:0]  cols_reg;
    logic               boxed_reg;
    logic               scroll_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic               cfg_wr;
    logic [2:0]         reg_idx;
    cfg_t               cfg;
    qhead_t             qhead;
    back_stat_t         bstat;

    // Register write completes on the access phase; reads never wait
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= RST_ROWS;
            cols_reg   <= RST_COLS;
            boxed_reg  <= 1'b0;
            scroll_reg <= 1'b0;
            fg_reg     <= RST_FG;
            bg_reg     <= RST_BG;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_ROWS:   rows_reg   <= pwdata[ROWS_W-1:0];
                REG_COLS:   cols_reg   <= pwdata[COLS_W-1:0];
                REG_BOXED:  boxed_reg  <= pwdata[0];
                REG_SCROLL: scroll_reg <= pwdata[0];
                REG_FG:     fg_reg     <= pwdata;
                REG_BG:     bg_reg     <= pwdata;
                default:
                begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROWS:   prdata = PDATA_W'(rows_reg);
            REG_COLS:   prdata = PDATA_W'(cols_reg);
            REG_BOXED:  prdata = PDATA_W'(boxed_reg);
            REG_SCROLL: prdata = PDATA_W'(scroll_reg);
            REG_FG:     prdata = fg_reg;
            REG_BG:     prdata = bg_reg;
            default:    prdata = '0;
        endcase
    end

    assign cfg.rows      = rows_reg;
    assign cfg.cols      = cols_reg;
    assign cfg.boxed     = boxed_reg;
    assign cfg.scroll_en = scroll_reg;
    assign cfg.fg        = fg_reg;
    assign cfg.bg        = bg_reg;

    // Front: accept and classify each transfer, queue it for the back end
    twcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .char_code  (char_code),
        .target_row (target_row),
        .target_col (target_col),
        .bstat      (bstat),
        .qhead      (qhead)
    );

    // Back: cursor, cell store, clear and scroll sweeps, result register
    twcw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .qhead      (qhead),
        .bstat      (bstat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_char  (cell_char),
        .cell_fg    (cell_fg),
        .cell_bg    (cell_bg),
        .cell_valid (cell_valid)
    );

endmodule
